[rtl/dwcm_pkg.sv]
package dwcm_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int FRAC_BITS = 12;
  localparam int FRAC_ONE = 4096;
  localparam int LEVEL_WIDTH = 13;
  localparam int GAIN_WIDTH = 16;
  localparam int GAIN_FRAC_BITS = 14;
  localparam int STEER_FRAC_BITS = 16;
  localparam int CODE_WIDTH = 8;
  localparam int ID_WIDTH = 11;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 16;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STEERING_GAIN = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LEFT_WHEEL_GAIN = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RIGHT_WHEEL_GAIN = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TURN_LEVEL = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MOTOR_MIN = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MOTOR_MAX = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WHEEL_MSG_ID = 3'd6;

  localparam logic [GAIN_WIDTH-1:0] RESET_STEERING_GAIN = 16'd6554;
  localparam logic [GAIN_WIDTH-1:0] RESET_WHEEL_GAIN = 16'd16384;
  localparam logic [LEVEL_WIDTH-1:0] RESET_TURN_LEVEL = 13'd410;
  localparam logic [CODE_WIDTH-1:0] RESET_MOTOR_MIN = 8'd130;
  localparam logic [CODE_WIDTH-1:0] RESET_MOTOR_MAX = 8'd255;
  localparam logic [ID_WIDTH-1:0] RESET_WHEEL_MSG_ID = 11'd0;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] speed;
    logic signed [VALUE_WIDTH-1:0] heading;
    logic                          direction;
    logic                          go_flag;
  } in_t;

  typedef struct packed {
    logic [ID_WIDTH-1:0]   frame_id;
    logic [CODE_WIDTH-1:0] right_speed;
    logic                  right_dir;
    logic [CODE_WIDTH-1:0] left_speed;
    logic                  left_dir;
    logic                  go_out;
  } out_t;

  typedef struct packed {
    logic [GAIN_WIDTH-1:0]  steering_gain;
    logic [GAIN_WIDTH-1:0]  left_wheel_gain;
    logic [GAIN_WIDTH-1:0]  right_wheel_gain;
    logic [LEVEL_WIDTH-1:0] turn_level;
    logic [CODE_WIDTH-1:0]  motor_min;
    logic [CODE_WIDTH-1:0]  motor_max;
    logic [ID_WIDTH-1:0]    wheel_msg_id;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic steer_en;
    logic mix_en;
    logic scale_en;
    logic map_en;
  } cmd_t;

  typedef struct packed {
    logic same;
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEER,
    ST_MIX,
    ST_SCALE,
    ST_MAP
  } state_t;

endpackage

[rtl/dwcm_cfg.sv]
module dwcm_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [dwcm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [dwcm_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  output dwcm_pkg::cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.steering_gain <= dwcm_pkg::RESET_STEERING_GAIN;
      cfg.left_wheel_gain <= dwcm_pkg::RESET_WHEEL_GAIN;
      cfg.right_wheel_gain <= dwcm_pkg::RESET_WHEEL_GAIN;
      cfg.turn_level <= dwcm_pkg::RESET_TURN_LEVEL;
      cfg.motor_min <= dwcm_pkg::RESET_MOTOR_MIN;
      cfg.motor_max <= dwcm_pkg::RESET_MOTOR_MAX;
      cfg.wheel_msg_id <= dwcm_pkg::RESET_WHEEL_MSG_ID;
    end else if (cfg_we) begin
      case (cfg_index)
        dwcm_pkg::CFG_STEERING_GAIN: begin
          cfg.steering_gain <= cfg_data;
        end
        dwcm_pkg::CFG_LEFT_WHEEL_GAIN: begin
          cfg.left_wheel_gain <= cfg_data;
        end
        dwcm_pkg::CFG_RIGHT_WHEEL_GAIN: begin
          cfg.right_wheel_gain <= cfg_data;
        end
        dwcm_pkg::CFG_TURN_LEVEL: begin
          cfg.turn_level <= cfg_data[dwcm_pkg::LEVEL_WIDTH-1:0];
        end
        dwcm_pkg::CFG_MOTOR_MIN: begin
          cfg.motor_min <= cfg_data[dwcm_pkg::CODE_WIDTH-1:0];
        end
        dwcm_pkg::CFG_MOTOR_MAX: begin
          cfg.motor_max <= cfg_data[dwcm_pkg::CODE_WIDTH-1:0];
        end
        dwcm_pkg::CFG_WHEEL_MSG_ID: begin
          cfg.wheel_msg_id <= cfg_data[dwcm_pkg::ID_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/dwcm_ctrl.sv]
module dwcm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  dwcm_pkg::status_t  status,
  output dwcm_pkg::cmd_t     cmd
);

  dwcm_pkg::state_t state, state_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dwcm_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall = 1'b1;
    cmd = '0;
    case (state)
      dwcm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
        if (in_valid && !status.same) begin
          state_next = dwcm_pkg::ST_STEER;
        end
      end
      dwcm_pkg::ST_STEER: begin
        cmd.steer_en = 1'b1;
        state_next = dwcm_pkg::ST_MIX;
      end
      dwcm_pkg::ST_MIX: begin
        cmd.mix_en = 1'b1;
        state_next = dwcm_pkg::ST_SCALE;
      end
      dwcm_pkg::ST_SCALE: begin
        cmd.scale_en = 1'b1;
        state_next = dwcm_pkg::ST_MAP;
      end
      dwcm_pkg::ST_MAP: begin
        if (!(out_valid && out_stall)) begin
          cmd.map_en = 1'b1;
          state_next = dwcm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dwcm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.map_en) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

endmodule

[rtl/dwcm_datapath.sv]
module dwcm_datapath (
  input  logic               clk,
  input  logic               rst,
  input  dwcm_pkg::cmd_t     cmd,
  input  dwcm_pkg::cfg_t     cfg,
  input  dwcm_pkg::in_t      in_data,
  output dwcm_pkg::status_t  status,
  output dwcm_pkg::out_t     out_data
);

  localparam int VW = dwcm_pkg::VALUE_WIDTH;
  localparam int LW = dwcm_pkg::LEVEL_WIDTH;
  localparam int GW = dwcm_pkg::GAIN_WIDTH;
  localparam int DW = VW + 2;
  localparam int PW = DW + GW + 1;
  localparam int SW = PW - dwcm_pkg::STEER_FRAC_BITS;
  localparam int MW = SW + 1;
  localparam int QW = LW + GW;
  localparam int NW = dwcm_pkg::CODE_WIDTH + dwcm_pkg::FRAC_BITS + 3;
  localparam logic signed [MW-1:0] ONE_MIX = MW'(dwcm_pkg::FRAC_ONE);
  localparam logic [QW-dwcm_pkg::GAIN_FRAC_BITS-1:0] ONE_SCALE =
    (QW-dwcm_pkg::GAIN_FRAC_BITS)'(dwcm_pkg::FRAC_ONE);

  dwcm_pkg::in_t          prev;
  dwcm_pkg::in_t          cur;
  logic signed [VW-1:0]   last_steer_heading;
  logic signed [PW-1:0]   steer_prod;
  logic [LW-1:0]          level_l;
  logic [LW-1:0]          level_r;
  logic                   dir_l;
  logic                   dir_r;
  logic [QW-1:0]          scaled_l;
  logic [QW-1:0]          scaled_r;

  logic                   fwd;
  logic                   turn;
  logic signed [DW-1:0]   diff;
  logic signed [SW-1:0]   steer;
  logic signed [MW-1:0]   sum_l;
  logic signed [MW-1:0]   sum_r;
  logic [LW-1:0]          lim_l;
  logic [LW-1:0]          lim_r;
  logic signed [9:0]      span;
  logic signed [NW-1:0]   base;
  logic signed [NW-1:0]   num_l;
  logic signed [NW-1:0]   num_r;

  function automatic logic [LW-1:0] clamp_unit(input logic signed [MW-1:0] x);
    logic [LW-1:0] r;
    if (x[MW-1]) begin
      r = '0;
    end else if (x > ONE_MIX) begin
      r = LW'(dwcm_pkg::FRAC_ONE);
    end else begin
      r = x[LW-1:0];
    end
    return r;
  endfunction

  function automatic logic [LW-1:0] limit_scaled(input logic [QW-1:0] p);
    logic [QW-dwcm_pkg::GAIN_FRAC_BITS-1:0] s;
    logic [LW-1:0] r;
    s = p[QW-1:dwcm_pkg::GAIN_FRAC_BITS];
    if (s > ONE_SCALE) begin
      r = LW'(dwcm_pkg::FRAC_ONE);
    end else begin
      r = s[LW-1:0];
    end
    return r;
  endfunction

  assign status.same = (in_data == prev);

  assign fwd = !cur.speed[VW-1] && (cur.speed != '0);
  assign turn = (cur.speed == '0) && (cur.heading != '0);
  assign diff = {cur.heading[VW-1], cur.heading, 1'b0}
              - {{2{last_steer_heading[VW-1]}}, last_steer_heading};
  assign steer = steer_prod[PW-1:dwcm_pkg::STEER_FRAC_BITS];
  assign sum_l = MW'(cur.speed) + MW'(steer);
  assign sum_r = MW'(cur.speed) - MW'(steer);

  assign lim_l = limit_scaled(scaled_l);
  assign lim_r = limit_scaled(scaled_r);
  assign span = $signed({2'b00, cfg.motor_max}) - $signed({2'b00, cfg.motor_min});
  assign base = $signed({3'b000, cfg.motor_min, {dwcm_pkg::FRAC_BITS{1'b0}}});
  assign num_l = base + NW'($signed({1'b0, lim_l}) * span);
  assign num_r = base + NW'($signed({1'b0, lim_r}) * span);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= '0;
      last_steer_heading <= '0;
    end else begin
      if (cmd.load && !status.same) begin
        prev <= in_data;
      end
      if (cmd.steer_en && fwd) begin
        last_steer_heading <= cur.heading;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= in_data;
    end
    if (cmd.steer_en) begin
      steer_prod <= diff * $signed({1'b0, cfg.steering_gain});
    end
    if (cmd.mix_en) begin
      if (turn) begin
        level_l <= cfg.turn_level;
        level_r <= cfg.turn_level;
        dir_l <= cur.heading[VW-1];
        dir_r <= !cur.heading[VW-1];
      end else if (fwd) begin
        level_l <= clamp_unit(sum_l);
        level_r <= clamp_unit(sum_r);
        dir_l <= cur.direction;
        dir_r <= cur.direction;
      end else begin
        level_l <= '0;
        level_r <= '0;
        dir_l <= cur.direction;
        dir_r <= cur.direction;
      end
    end
    if (cmd.scale_en) begin
      scaled_l <= level_l * cfg.left_wheel_gain;
      scaled_r <= level_r * cfg.right_wheel_gain;
    end
    if (cmd.map_en) begin
      out_data.frame_id <= cfg.wheel_msg_id;
      out_data.right_speed <= num_r[dwcm_pkg::FRAC_BITS +: dwcm_pkg::CODE_WIDTH];
      out_data.right_dir <= dir_r;
      out_data.left_speed <= num_l[dwcm_pkg::FRAC_BITS +: dwcm_pkg::CODE_WIDTH];
      out_data.left_dir <= dir_l;
      out_data.go_out <= cur.go_flag;
    end
  end

endmodule

[rtl/differential_wheel_command_mixer_unit.sv]
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   dwcm_pkg::in_t (speed, heading, direction, go)
// out       output     out_valid / out_stall dwcm_pkg::out_t (one wheel frame)
// cfg       input      cfg_we                cfg_index, cfg_data
//
// A new command is loaded at its accepting edge and presents its frame after these steps:
// the steering multiply, the mix and clamp, the wheel gain multiply and the motor code
// multiply, each a state of one shared sequencer, with the input stalled meanwhile, so
// a new command is taken only once the last frame is written. A repeated command is
// dropped in its accepting cycle. Reset is synchronous and restores the register defaults
// and the remembered command. A frame waits in the output register under stall while the
// next command is taken in; the final step holds until that register is free.
module differential_wheel_command_mixer_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  dwcm_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output dwcm_pkg::out_t                       out_data,
  input  logic                                 cfg_we,
  input  logic [dwcm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [dwcm_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

  dwcm_pkg::cfg_t    cfg;
  dwcm_pkg::cmd_t    cmd;
  dwcm_pkg::status_t status;

  dwcm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dwcm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  dwcm_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .in_data  (in_data),
    .status   (status),
    .out_data (out_data)
  );

  a_map_free: assert property (@(posedge clk) disable iff (rst)
    !(cmd.map_en && out_valid && out_stall))
    else $error("frame written over a stalled result");

  a_busy_after_new: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !status.same) |=> in_stall)
    else $error("new command did not start the sequencer");

  a_map_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.map_en |=> out_valid)
    else $error("finished frame not presented");

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.steer_en, cmd.mix_en, cmd.scale_en, cmd.map_en}))
    else $error("more than one datapath step in a cycle");

endmodule
